@@ rtl/dnplfc_pkg.sv @@
// shared types, codes and crc function for the dnp3 link frame checker
package dnplfc_pkg;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_EXT_ADDR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROLE     = 1'd1;

    localparam logic [7:0]  START_BYTE_A   = 8'h05;
    localparam logic [7:0]  START_BYTE_B   = 8'h64;
    localparam logic [7:0]  HEADER_FIELDS  = 8'd5;
    localparam logic [4:0]  DATA_BLOCK_MAX = 5'd16;
    localparam logic [4:0]  HDR_IDX_FIRST  = 5'd3;
    localparam logic [4:0]  HDR_IDX_DST_LO = 5'd4;
    localparam logic [4:0]  HDR_IDX_DST_HI = 5'd5;
    localparam logic [4:0]  HDR_IDX_END    = 5'd8;
    localparam logic [15:0] CRC_POLY_REFL  = 16'hA6BC;

    localparam logic [1:0] ROLE_GATEWAY  = 2'd1;
    localparam logic [1:0] ROLE_TERMINAL = 2'd2;

    localparam logic [1:0] ROUTE_EXTERNAL   = 2'd0;
    localparam logic [1:0] ROUTE_DOWNSTREAM = 2'd1;
    localparam logic [1:0] ROUTE_POWER      = 2'd2;
    localparam logic [1:0] ROUTE_NONE       = 2'd3;

    typedef enum logic [2:0] {
        ERR_NONE  = 3'd0,
        ERR_START = 3'd1,
        ERR_LEN   = 3'd2,
        ERR_CRC   = 3'd3,
        ERR_TRUNC = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_HDR   = 3'd3,
        PH_DATA  = 3'd4,
        PH_CRCLO = 3'd5,
        PH_CRCHI = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       data_last;
    } in_item_t;

    typedef struct packed {
        logic        frame_ok;
        logic [2:0]  error_code;
        logic [15:0] dest_address;
        logic [1:0]  route;
        logic [4:0]  block_count;
    } out_item_t;

    // handshake controls between the stages
    typedef struct packed {
        logic item_valid;
        logic advance;
    } stage_ctl_t;

    // reflected dnp crc-16, one byte per call
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY_REFL;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

@@ rtl/dnplfc_if.sv @@
// valid/ready stream interfaces for bytes in and frame results out
interface dnplfc_in_if;
    import dnplfc_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dnplfc_out_if;
    import dnplfc_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/dnplfc_in_stage.sv @@
// input register stage holding one received byte
module dnplfc_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    dnplfc_in_if.sink              byte_stream,
    input  logic                   advance,
    output logic                   item_valid,
    output dnplfc_pkg::in_item_t   item
);
    import dnplfc_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     load;

    assign byte_stream.ready = !valid_reg || advance;
    assign load              = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (byte_stream.ready)
            valid_next = byte_stream.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= byte_stream.payload;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ rtl/dnplfc_frame_fsm.sv @@
// frame parser: phase tracking, crc checking and result formation
module dnplfc_frame_fsm (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dnplfc_pkg::stage_ctl_t ctl,
    input  dnplfc_pkg::in_item_t   item,
    input  logic [15:0]            ext_addr,
    input  logic [1:0]             role,
    output logic                   res_valid,
    output dnplfc_pkg::out_item_t  res
);
    import dnplfc_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  lo_reg, lo_next;
    logic [15:0] dest_reg, dest_next;
    logic [4:0]  blk_reg, blk_next;
    logic        fin;
    err_t        fin_err;
    logic        check_last;
    logic        step;
    logic [15:0] crc_fed;
    logic [7:0]  b;

    assign step    = ctl.item_valid && ctl.advance;
    assign b       = item.data_byte;
    assign crc_fed = crc_feed(item.frame_start ? 16'h0000 : crc_reg, b);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        len_next   = len_reg;
        crc_next   = crc_reg;
        lo_next    = lo_reg;
        dest_next  = dest_reg;
        blk_next   = blk_reg;
        fin        = 1'b0;
        fin_err    = ERR_NONE;
        check_last = 1'b1;
        if (item.frame_start)
        begin
            crc_next   = 16'h0000;
            lo_next    = 8'h00;
            dest_next  = 16'h0000;
            blk_next   = 5'd0;
            idx_next   = 5'd0;
            len_next   = 8'd0;
            phase_next = PH_SYNC2;
            if (b != START_BYTE_A)
            begin
                fin        = 1'b1;
                fin_err    = ERR_START;
                check_last = 1'b0;
            end
            else
                crc_next = crc_fed;
        end
        else
        begin
            case (phase_reg)
                PH_SYNC2:
                begin
                    if (b != START_BYTE_B)
                    begin
                        fin        = 1'b1;
                        fin_err    = ERR_START;
                        check_last = 1'b0;
                    end
                    else
                    begin
                        crc_next   = crc_fed;
                        phase_next = PH_LEN;
                    end
                end
                PH_LEN:
                begin
                    if (b < HEADER_FIELDS)
                    begin
                        fin        = 1'b1;
                        fin_err    = ERR_LEN;
                        check_last = 1'b0;
                    end
                    else
                    begin
                        crc_next   = crc_fed;
                        len_next   = b - HEADER_FIELDS;
                        idx_next   = HDR_IDX_FIRST;
                        phase_next = PH_HDR;
                    end
                end
                PH_HDR:
                begin
                    crc_next = crc_fed;
                    if (idx_reg == HDR_IDX_DST_LO)
                        dest_next[7:0] = b;
                    else if (idx_reg == HDR_IDX_DST_HI)
                        dest_next[15:8] = b;
                    idx_next = idx_reg + 5'd1;
                    if (idx_next >= HDR_IDX_END)
                        phase_next = PH_CRCLO;
                end
                PH_DATA:
                begin
                    crc_next = crc_fed;
                    idx_next = idx_reg + 5'd1;
                    if (len_reg != 8'd0)
                        len_next = len_reg - 8'd1;
                    if (idx_next >= DATA_BLOCK_MAX || len_next == 8'd0)
                        phase_next = PH_CRCLO;
                end
                PH_CRCLO:
                begin
                    lo_next    = b;
                    phase_next = PH_CRCHI;
                end
                PH_CRCHI:
                begin
                    if ({b, lo_reg} != ~crc_reg)
                    begin
                        fin        = 1'b1;
                        fin_err    = ERR_CRC;
                        check_last = 1'b0;
                    end
                    else
                    begin
                        blk_next = blk_reg + 5'd1;
                        if (len_reg == 8'd0)
                        begin
                            fin        = 1'b1;
                            fin_err    = ERR_NONE;
                            check_last = 1'b0;
                        end
                        else
                        begin
                            crc_next   = 16'h0000;
                            idx_next   = 5'd0;
                            phase_next = PH_DATA;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    check_last = 1'b0;
                end
            endcase
        end
        if (!fin && check_last && item.data_last && phase_next != PH_IDLE)
        begin
            fin     = 1'b1;
            fin_err = ERR_TRUNC;
        end
        if (fin)
            phase_next = PH_IDLE;
    end

    // outputs
    always_comb
    begin
        res_valid        = step && fin;
        res.frame_ok     = (fin_err == ERR_NONE);
        res.error_code   = fin_err;
        res.dest_address = dest_next;
        res.block_count  = blk_next;
        res.route        = ROUTE_NONE;
        if (fin_err == ERR_NONE)
        begin
            if (dest_next == ext_addr)
                res.route = ROUTE_EXTERNAL;
            else if (role == ROLE_GATEWAY)
                res.route = ROUTE_DOWNSTREAM;
            else if (role == ROLE_TERMINAL)
                res.route = ROUTE_POWER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= 5'd0;
            len_reg   <= 8'd0;
            crc_reg   <= 16'h0000;
            lo_reg    <= 8'h00;
            dest_reg  <= 16'h0000;
            blk_reg   <= 5'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            crc_reg   <= crc_next;
            lo_reg    <= lo_next;
            dest_reg  <= dest_next;
            blk_reg   <= blk_next;
        end
    end

endmodule

@@ rtl/dnplfc_out_stage.sv @@
// result register driving the result stream
module dnplfc_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  res_valid,
    input  dnplfc_pkg::out_item_t res,
    output logic                  advance,
    dnplfc_out_if.source          frame_result
);
    import dnplfc_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t res_reg;

    assign advance = !valid_reg || frame_result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
            valid_next = res_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
            res_reg <= res;
    end

    assign frame_result.valid   = valid_reg;
    assign frame_result.payload = res_reg;

endmodule

@@ rtl/dnp3_link_frame_checker.sv @@
// top level of the dnp3 link frame checker
// Checks DNP3 link frames in a byte stream, one byte per cycle in sustained
// operation while frame_result accepts results. A byte with frame_start set
// opens a candidate frame (any frame in progress is dropped silently). The
// checker verifies the 05 64 start bytes, rejects LEN below 5, checks the
// 8-byte header block and each data block of up to 16 bytes against its DNP
// CRC-16 (low byte first), and emits one result when the frame completes or
// fails; a byte with data_last that leaves a frame open fails it as truncated.
// The byte that ends a frame sits in the input register while the byte-wide CRC
// update and parse step feed the result register, which drives frame_result.
// While a result waits, the input register can still take one byte if it is
// empty. Route is external when the destination equals external_unit_address,
// else follows device_role; failed frames report route none.
module dnp3_link_frame_checker (
    input  logic                                  clk,
    input  logic                                  rst_n,
    dnplfc_in_if.sink                             byte_stream,
    dnplfc_out_if.source                          frame_result,
    input  logic                                  cfg_wr_en,
    input  logic [dnplfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dnplfc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import dnplfc_pkg::*;

    // configuration registers
    logic [15:0] ext_addr_reg;
    logic [1:0]  role_reg;

    // stage handshake
    stage_ctl_t  ctl;
    logic        item_valid;
    logic        advance;
    in_item_t    item;

    // parser result toward the result register
    logic        res_valid;
    out_item_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_addr_reg <= 16'h0000;
            role_reg     <= 2'd0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_IDX_EXT_ADDR: ext_addr_reg <= cfg_wdata[15:0];
                CFG_IDX_ROLE:     role_reg     <= cfg_wdata[1:0];
                default:          ;
            endcase
        end
    end

    // input register, advances whenever the result register can take a transfer
    dnplfc_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_stream),
        .advance     (advance),
        .item_valid  (item_valid),
        .item        (item)
    );

    assign ctl.item_valid = item_valid;
    assign ctl.advance    = advance;

    // single-pass parse and crc step on the registered byte
    dnplfc_frame_fsm u_frame_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .item      (item),
        .ext_addr  (ext_addr_reg),
        .role      (role_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register
    dnplfc_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res          (res),
        .advance      (advance),
        .frame_result (frame_result)
    );

`ifndef NO_ASSERTIONS
    // a result only appears from a byte that sat in the input register
    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_result.valid) |-> $past(item_valid))
        else $error("result appeared without a byte in the input register");

    // a good frame carries no error code, a failed one routes nowhere
    a_ok_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        frame_result.valid |->
        ((frame_result.payload.frame_ok == (frame_result.payload.error_code == ERR_NONE))
         && (frame_result.payload.frame_ok || frame_result.payload.route == ROUTE_NONE)))
        else $error("frame_ok, error_code and route disagree");

    // a good frame passed at least the header block
    a_ok_has_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        frame_result.valid && frame_result.payload.frame_ok |->
        frame_result.payload.block_count != 5'd0)
        else $error("good frame reported with no passed blocks");

    // the input register never advances while the result register is stuck
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        frame_result.valid && !frame_result.ready |-> !advance)
        else $error("stage advanced while the result was stalled");
`endif

endmodule
